### hw/rtl/xxh_pkg.sv
// Shared types, primes and helpers for the xxHash32 stream hasher.
package xxh_pkg;

	localparam int WORD_W = 32;
	localparam int CNT_W  = 3;
	localparam int FILL_W = 4;

	localparam logic [WORD_W-1:0] PRIME1 = 32'h9E37_79B1;
	localparam logic [WORD_W-1:0] PRIME2 = 32'h85EB_CA77;
	localparam logic [WORD_W-1:0] PRIME3 = 32'hC2B2_AE3D;
	localparam logic [WORD_W-1:0] PRIME4 = 32'h27D4_EB2F;
	localparam logic [WORD_W-1:0] PRIME5 = 32'h1656_67B1;

	localparam logic [CNT_W-1:0] MAX_BYTES  = 3'd4;
	localparam logic [3:0]       ROUND_LAST = 4'd8;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INSERT,
		ST_ROUND,
		ST_MERGE,
		ST_WMUL,
		ST_WROT,
		ST_WSAVE,
		ST_BMUL,
		ST_BROT,
		ST_BSAVE,
		ST_AV1,
		ST_AV2,
		ST_OUT
	} state_t;

	// Control from the sequencer to the stripe buffer
	typedef struct packed {
		logic             clear;
		logic             insert;
		logic [CNT_W-1:0] rem;
	} buf_ctl_t;

	// Status from the stripe buffer to the sequencer
	typedef struct packed {
		logic [FILL_W-1:0] fill;
		logic [CNT_W-1:0]  seg;
		logic              full;
	} buf_st_t;

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
		input logic [4:0] s);
		return (v << s) | (v >> (6'd32 - {1'b0, s}));
	endfunction

endpackage

### hw/rtl/xxh_if.sv
// Stream channel interfaces: message words in, hash values out.
interface xxh_word_if;
	import xxh_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] data_word;
	logic [CNT_W-1:0]  byte_count;
	logic              last_word;

	modport source(output valid, data_word, byte_count, last_word, input ready);
	modport sink(input valid, data_word, byte_count, last_word, output ready);
endinterface

interface xxh_hash_if;
	import xxh_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] hash_value;

	modport source(output valid, hash_value, input ready);
	modport sink(input valid, hash_value, output ready);
endinterface

### hw/rtl/xxh_mul.sv
// Shared 32x32 multiplier, low product half registered.
module xxh_mul (
	input  logic                      clk,
	input  logic                      en,
	input  logic [xxh_pkg::WORD_W-1:0] a,
	input  logic [xxh_pkg::WORD_W-1:0] b,
	output logic [xxh_pkg::WORD_W-1:0] p
);
	import xxh_pkg::*;

	logic [2*WORD_W-1:0] prod;
	logic [WORD_W-1:0]   p_q;

	assign prod = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};

	// Hold the product while the sequencer does not need a new one
	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= prod[WORD_W-1:0];
		end
	end

	assign p = p_q;
endmodule

### hw/rtl/xxh_stripe_buf.sv
// 16-byte stripe buffer with byte insert, fill count and one word read port.
module xxh_stripe_buf (
	input  logic                      clk,
	input  logic                      arst_n,
	input  xxh_pkg::buf_ctl_t         ctl,
	input  logic [xxh_pkg::WORD_W-1:0] word,
	input  logic [1:0]                rd_idx,
	output xxh_pkg::buf_st_t          st,
	output logic [xxh_pkg::WORD_W-1:0] rd_word
);
	import xxh_pkg::*;

	logic [7:0]        byte_q [16];
	logic [FILL_W-1:0] fill_q;
	logic [4:0]        room;
	logic [4:0]        fill_sum;
	logic              wr_en  [16];
	logic [1:0]        wr_sel [16];

	// Segment that fits before the stripe is full
	always_comb begin
		room = 5'd16 - {1'b0, fill_q};
		if ({2'b00, ctl.rem} < room) begin
			st.seg = ctl.rem;
		end else begin
			st.seg = room[CNT_W-1:0];
		end
		fill_sum = {1'b0, fill_q} + {2'b00, st.seg};
		st.full  = fill_sum[4];
		st.fill  = fill_q;
	end

	// Decode which byte slots take which input byte
	always_comb begin
		for (int p = 0; p < 16; p++) begin
			logic [3:0] off;
			off       = 4'(p) - fill_q;
			wr_en[p]  = ctl.insert && (off < {1'b0, st.seg});
			wr_sel[p] = off[1:0];
		end
	end

	// Write bytes
	always_ff @(posedge clk) begin
		for (int p = 0; p < 16; p++) begin
			if (wr_en[p]) begin
				byte_q[p] <= word[wr_sel[p]*8 +: 8];
			end
		end
	end

	// Advance the fill count, wrap on a full stripe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctl.clear) begin
			fill_q <= '0;
		end else if (ctl.insert) begin
			fill_q <= fill_sum[FILL_W-1:0];
		end
	end

	assign rd_word = {byte_q[{rd_idx, 2'd3}], byte_q[{rd_idx, 2'd2}],
		byte_q[{rd_idx, 2'd1}], byte_q[{rd_idx, 2'd0}]};
endmodule

### hw/rtl/xxhash32_stream_hasher.sv
// Top level: xxHash32 over a word stream with one shared multiplier and a sequencer.
//
//   channel  dir  handshake     payload
//   msg      in   valid/ready   data_word[31:0], byte_count[2:0], last_word
//   result   out  valid/ready   hash_value[31:0]
//   seed     in   seed_we       seed_value[31:0]
//
// A word passes through accept (idle) and byte insert; a word that completes a 16-byte
// stripe adds the lane rounds, two multiplies per lane on the shared
// multiplier, and more if its bytes spill into the next stripe.
// A last word adds a merge step, a multiply, rotate and save step per buffered tail word and
// per tail byte, and the avalanche states AV1, AV2 and OUT. msg.ready is high only in the idle state.
// The result register lets the next message start while a hash waits to be taken.
// Reset clears the seed, the lanes and all control state.
module xxhash32_stream_hasher (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       seed_we,
	input  logic [xxh_pkg::WORD_W-1:0] seed_value,
	xxh_word_if.sink                   msg,
	xxh_hash_if.source                 result
);
	import xxh_pkg::*;

	state_t            state_q, state_d;
	logic [WORD_W-1:0] seed_q;
	logic [WORD_W-1:0] lane_q [4];
	logic [WORD_W-1:0] len_q;
	logic              long_q;
	logic              open_q;
	logic [WORD_W-1:0] word_q;
	logic [CNT_W-1:0]  rem_q;
	logic              last_q;
	logic [3:0]        rnd_q;
	logic [3:0]        tail_i_q, tail_i_d;
	logic [WORD_W-1:0] h_q;
	logic [WORD_W-1:0] hash_q;
	logic              out_valid_q;

	logic              accept;
	logic [CNT_W-1:0]  cnt_c;
	logic              mul_en;
	logic [WORD_W-1:0] mul_a, mul_b, mul_p;
	buf_ctl_t          buf_ctl;
	buf_st_t           buf_st;
	logic [1:0]        rd_idx;
	logic [WORD_W-1:0] rd_word;
	logic [WORD_W-1:0] merge_sum;
	logic [3:0]        tail_left;
	logic              out_load;
	logic [1:0]        lane_wr_idx;

	assign accept   = msg.valid && msg.ready;
	assign msg.ready = (state_q == ST_IDLE);
	assign cnt_c    = (msg.byte_count > MAX_BYTES) ? MAX_BYTES : msg.byte_count;

	xxh_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	xxh_stripe_buf u_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (buf_ctl),
		.word    (word_q),
		.rd_idx  (rd_idx),
		.st      (buf_st),
		.rd_word (rd_word)
	);

	assign rd_idx      = (state_q == ST_ROUND) ? rnd_q[2:1] : tail_i_q[3:2];
	assign lane_wr_idx = 2'(rnd_q[3:1] - 3'd1);
	assign merge_sum   = long_q ?
		(rotl(lane_q[0], 5'd1) + rotl(lane_q[1], 5'd7) +
		 rotl(lane_q[2], 5'd12) + rotl(lane_q[3], 5'd18)) :
		(lane_q[2] + PRIME5);

	// Next state, multiplier operands and buffer control
	always_comb begin
		state_d     = state_q;
		mul_en      = 1'b0;
		mul_a       = '0;
		mul_b       = '0;
		buf_ctl     = '0;
		buf_ctl.rem = rem_q;
		out_load    = 1'b0;
		tail_i_d    = tail_i_q;
		tail_left   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					buf_ctl.clear = !open_q;
					state_d       = ST_INSERT;
				end
			end
			ST_INSERT: begin
				buf_ctl.insert = 1'b1;
				if (buf_st.full) begin
					state_d = ST_ROUND;
				end else if (last_q) begin
					state_d = ST_MERGE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_ROUND: begin
				mul_en = 1'b1;
				if (!rnd_q[0]) begin
					mul_a = rd_word;
					mul_b = PRIME2;
				end else begin
					mul_a = rotl(lane_q[rnd_q[2:1]] + mul_p, 5'd13);
					mul_b = PRIME1;
				end
				if (rnd_q == ROUND_LAST) begin
					mul_en = 1'b0;
					if (rem_q != '0) begin
						state_d = ST_INSERT;
					end else if (last_q) begin
						state_d = ST_MERGE;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_WMUL: begin
				mul_en  = 1'b1;
				mul_a   = rd_word;
				mul_b   = PRIME3;
				state_d = ST_WROT;
			end
			ST_WROT: begin
				mul_en  = 1'b1;
				mul_a   = rotl(h_q + mul_p, 5'd17);
				mul_b   = PRIME4;
				state_d = ST_WSAVE;
			end
			ST_BMUL: begin
				mul_en  = 1'b1;
				mul_a   = {24'd0, rd_word[{tail_i_q[1:0], 3'd0} +: 8]};
				mul_b   = PRIME5;
				state_d = ST_BROT;
			end
			ST_BROT: begin
				mul_en  = 1'b1;
				mul_a   = rotl(h_q + mul_p, 5'd11);
				mul_b   = PRIME1;
				state_d = ST_BSAVE;
			end
			ST_MERGE, ST_WSAVE, ST_BSAVE: begin
				// Pick the next tail step: whole words first, then bytes
				priority case (state_q)
					ST_MERGE: tail_i_d = '0;
					ST_WSAVE: tail_i_d = tail_i_q + 4'd4;
					default:  tail_i_d = tail_i_q + 4'd1;
				endcase
				tail_left = buf_st.fill - tail_i_d;
				if (tail_left >= 4'd4) begin
					state_d = ST_WMUL;
				end else if (tail_left != '0) begin
					state_d = ST_BMUL;
				end else begin
					state_d = ST_AV1;
				end
			end
			ST_AV1: begin
				mul_en  = 1'b1;
				mul_a   = h_q ^ (h_q >> 15);
				mul_b   = PRIME2;
				state_d = ST_AV2;
			end
			ST_AV2: begin
				mul_en  = 1'b1;
				mul_a   = mul_p ^ (mul_p >> 13);
				mul_b   = PRIME3;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_load = !out_valid_q || result.ready;
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (seed_we) begin
			seed_q <= seed_value;
		end
	end

	// Message state: lanes, length, stripe flag, pending bytes, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) begin
				lane_q[k] <= '0;
			end
			len_q    <= '0;
			long_q   <= 1'b0;
			open_q   <= 1'b0;
			rem_q    <= '0;
			last_q   <= 1'b0;
			rnd_q    <= '0;
			tail_i_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!open_q) begin
							lane_q[0] <= seed_q + PRIME1 + PRIME2;
							lane_q[1] <= seed_q + PRIME2;
							lane_q[2] <= seed_q;
							lane_q[3] <= seed_q - PRIME1;
							long_q    <= 1'b0;
							len_q     <= {{(WORD_W-CNT_W){1'b0}}, cnt_c};
						end else begin
							len_q <= len_q + {{(WORD_W-CNT_W){1'b0}}, cnt_c};
						end
						open_q <= !msg.last_word;
						rem_q  <= cnt_c;
						last_q <= msg.last_word;
					end
				end
				ST_INSERT: begin
					rem_q <= rem_q - buf_st.seg;
					rnd_q <= '0;
				end
				ST_ROUND: begin
					if (!rnd_q[0] && rnd_q != '0) begin
						lane_q[lane_wr_idx] <= mul_p;
					end
					if (rnd_q == ROUND_LAST) begin
						long_q <= 1'b1;
					end
					rnd_q <= rnd_q + 4'd1;
				end
				ST_MERGE, ST_WSAVE, ST_BSAVE: begin
					tail_i_q <= tail_i_d;
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath: pending word and running hash
	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= msg.data_word;
		end else if (state_q == ST_INSERT) begin
			word_q <= word_q >> {buf_st.seg, 3'd0};
		end
		if (state_q == ST_MERGE) begin
			h_q <= merge_sum + len_q;
		end else if (state_q == ST_WSAVE || state_q == ST_BSAVE) begin
			h_q <= mul_p;
		end
		if (out_load) begin
			hash_q <= mul_p ^ (mul_p >> 16);
		end
	end

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.hash_value = hash_q;
endmodule

### tb/xxh_hash_checker.sv
// Checker for the xxHash32 stream hasher: predicts each hash from the word beats and compares.
module xxh_hash_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       seed_we,
	input  logic [xxh_pkg::WORD_W-1:0] seed_value,
	xxh_word_if                        msg,
	xxh_hash_if                        result,
	output int unsigned                mismatches,
	output int unsigned                pending
);
	import xxh_pkg::*;

	// Shadow copy of the hasher state
	logic [WORD_W-1:0] seed_q;
	logic [WORD_W-1:0] lane [4];
	logic [7:0]        tail_bytes [16];
	logic [3:0]        fill;
	logic [WORD_W-1:0] msg_len;
	logic              seen_stripe;
	logic              msg_open;

	logic [WORD_W-1:0] expected_hashes [$];
	logic [WORD_W-1:0] want;
	int unsigned       err_cnt;

	function automatic logic [WORD_W-1:0] rot_left(input logic [WORD_W-1:0] v,
		input int unsigned s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic logic [WORD_W-1:0] lane_mix(input logic [WORD_W-1:0] acc,
		input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] t;
		t = acc + w * PRIME2;
		return rot_left(t, 13) * PRIME1;
	endfunction

	function automatic logic [WORD_W-1:0] stripe_word(input int unsigned k);
		return {tail_bytes[4*k+3], tail_bytes[4*k+2], tail_bytes[4*k+1], tail_bytes[4*k]};
	endfunction

	// Append one byte; run the four lane rounds when the stripe fills
	task automatic take_byte(input logic [7:0] b);
		int unsigned k;
		tail_bytes[fill] = b;
		if (fill == 4'd15) begin
			for (k = 0; k < 4; k++)
				lane[k] = lane_mix(lane[k], stripe_word(k));
			seen_stripe = 1'b1;
			fill = 4'd0;
		end else begin
			fill = fill + 4'd1;
		end
	endtask

	// Merge lanes, fold the tail, avalanche
	function automatic logic [WORD_W-1:0] seal_hash();
		logic [WORD_W-1:0] h;
		int unsigned       i;
		int unsigned       n;
		n = {28'd0, fill};
		if (seen_stripe)
			h = rot_left(lane[0], 1) + rot_left(lane[1], 7)
				+ rot_left(lane[2], 12) + rot_left(lane[3], 18);
		else
			h = lane[2] + PRIME5;
		h = h + msg_len;
		i = 0;
		while (i + 4 <= n) begin
			h = h + stripe_word(i / 4) * PRIME3;
			h = rot_left(h, 17) * PRIME4;
			i += 4;
		end
		while (i < n) begin
			h = h + {24'd0, tail_bytes[i]} * PRIME5;
			h = rot_left(h, 11) * PRIME1;
			i++;
		end
		h = h ^ (h >> 15);
		h = h * PRIME2;
		h = h ^ (h >> 13);
		h = h * PRIME3;
		h = h ^ (h >> 16);
		return h;
	endfunction

	// Absorb one word beat; queue a hash when it closes the message
	task automatic absorb_word(input logic [WORD_W-1:0] d, input logic [CNT_W-1:0] c,
		input logic l);
		int unsigned n;
		int unsigned k;
		if (!msg_open) begin
			lane[0]     = seed_q + PRIME1 + PRIME2;
			lane[1]     = seed_q + PRIME2;
			lane[2]     = seed_q;
			lane[3]     = seed_q - PRIME1;
			fill        = 4'd0;
			msg_len     = '0;
			seen_stripe = 1'b0;
			msg_open    = 1'b1;
		end
		n = {29'd0, ((c > MAX_BYTES) ? MAX_BYTES : c)};
		for (k = 0; k < n; k++)
			take_byte(d[8*k +: 8]);
		msg_len = msg_len + n;
		if (l) begin
			expected_hashes.push_back(seal_hash());
			msg_open = 1'b0;
		end
	endtask

	// Watch both channels and the seed port at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      = '0;
			fill        = 4'd0;
			msg_len     = '0;
			seen_stripe = 1'b0;
			msg_open    = 1'b0;
			err_cnt     = 0;
			for (int k = 0; k < 4; k++)
				lane[k] = '0;
			expected_hashes.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (msg.valid && msg.ready)
				absorb_word(msg.data_word, msg.byte_count, msg.last_word);
			if (result.valid && result.ready) begin
				if (expected_hashes.size() == 0) begin
					err_cnt++;
					$display("%0t: hash expected none, got %08h", $time, result.hash_value);
				end else begin
					want = expected_hashes.pop_front();
					if (result.hash_value !== want) begin
						err_cnt++;
						$display("%0t: hash expected %08h, got %08h", $time, want,
							result.hash_value);
					end
				end
			end
			if (seed_we)
				seed_q = seed_value;
			mismatches <= err_cnt;
			pending    <= expected_hashes.size();
		end
	end

endmodule

### tb/tb.sv
// Testbench top for the xxHash32 stream hasher: clock, reset, word stimulus, receiver, verdict.
module tb;
	import xxh_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 550;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES = 40;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              seed_we;
	logic [WORD_W-1:0] seed_value;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned hold_reqs;
	int unsigned burst_left;
	int unsigned rand_items;

	xxh_word_if msg_if();
	xxh_hash_if hash_if();

	xxhash32_stream_hasher u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed_we   (seed_we),
		.seed_value(seed_value),
		.msg       (msg_if),
		.result    (hash_if)
	);

	xxh_hash_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed_we   (seed_we),
		.seed_value(seed_value),
		.msg       (msg_if),
		.result    (hash_if),
		.mismatches(mismatches),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	initial begin
		#2_000_000;
		$display("xxhash32_stream_hasher: mismatch");
		$finish;
	end

	// Drive ready: random modes per window, plus long hold-offs on request
	initial begin
		int unsigned win;
		int unsigned mode;
		int unsigned held;
		int unsigned hold_done;
		hash_if.ready = 1'b0;
		win       = 0;
		mode      = 0;
		held      = 0;
		hold_done = 0;
		forever begin
			@(posedge clk);
			if (hold_done != hold_reqs) begin
				hash_if.ready <= 1'b0;
				held++;
				if (held == HOLD_CYCLES) begin
					held = 0;
					hold_done++;
				end
			end else begin
				if (win == 0) begin
					mode = $urandom_range(0, 3);
					win  = $urandom_range(20, 80);
				end
				win--;
				case (mode)
					0: hash_if.ready <= 1'b1;
					1: hash_if.ready <= 1'($urandom_range(0, 1));
					2: hash_if.ready <= ($urandom_range(0, 7) == 0);
					default: hash_if.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Offer one word beat and hold it until taken; insert a gap at burst end
	task automatic put_word(input logic [WORD_W-1:0] d, input logic [CNT_W-1:0] c,
		input logic l);
		int unsigned gap;
		msg_if.valid      <= 1'b1;
		msg_if.data_word  <= d;
		msg_if.byte_count <= c;
		msg_if.last_word  <= l;
		do @(posedge clk); while (!msg_if.ready);
		if (burst_left == 0) begin
			gap        = $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
			msg_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	// Drop valid, wait for every hash, then let the block go quiet
	task automatic settle();
		msg_if.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic [WORD_W-1:0] v);
		seed_we    <= 1'b1;
		seed_value <= v;
		@(posedge clk);
		seed_we <= 1'b0;
	endtask

	function automatic logic [WORD_W-1:0] pick_data();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// One random message; well-formed ones use full words until the last
	task automatic send_message(input bit broken);
		int unsigned      nwords;
		int unsigned      sz;
		int unsigned      i;
		logic [CNT_W-1:0] c;
		sz = $urandom_range(0, 19);
		nwords = (sz < 14) ? $urandom_range(1, 6)
			: (sz < 19) ? $urandom_range(7, 16) : $urandom_range(17, 40);
		for (i = 0; i < nwords; i++) begin
			if (broken)
				c = 3'($urandom_range(0, 7));
			else if (i == nwords - 1)
				c = ($urandom_range(0, 9) == 0) ? 3'd0 : 3'($urandom_range(1, 4));
			else
				c = MAX_BYTES;
			put_word(pick_data(), c, i == nwords - 1);
		end
		rand_items += nwords;
	endtask

	function automatic logic [WORD_W-1:0] pick_seed(input int unsigned phase);
		case (phase)
			0: return '0;
			1: return '1;
			2: return 32'h0000_0001;
			3: return 32'h8000_0000;
			default: begin
				case ($urandom_range(0, 5))
					0: return '0;
					1: return '1;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	// Stimulus: directed cases, then phases of random messages under new seeds
	initial begin
		int unsigned phase;
		int unsigned m;
		arst_n            = 1'b0;
		seed_we           = 1'b0;
		seed_value        = '0;
		msg_if.valid      = 1'b0;
		msg_if.data_word  = '0;
		msg_if.byte_count = '0;
		msg_if.last_word  = 1'b0;
		hold_reqs         = 0;
		burst_left        = 0;
		rand_items        = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty message, single bytes and one word at the extremes
		put_word('0, 3'd0, 1'b1);
		put_word('1, 3'd1, 1'b1);
		put_word('1, MAX_BYTES, 1'b1);
		// exactly one stripe, then one stripe plus a byte
		repeat (3) put_word('0, MAX_BYTES, 1'b0);
		put_word('0, MAX_BYTES, 1'b1);
		repeat (4) put_word('1, MAX_BYTES, 1'b0);
		put_word('1, 3'd1, 1'b1);
		// count above four
		put_word(32'hA5A5_A5A5, 3'd7, 1'b1);
		// partial word before the last
		put_word(32'h1234_5678, 3'd2, 1'b0);
		put_word(32'h9ABC_DEF0, MAX_BYTES, 1'b1);
		// zero count mid-message, then zero count on the last word
		put_word(32'hDEAD_BEEF, 3'd0, 1'b0);
		put_word(32'hCAFE_F00D, 3'd3, 1'b1);
		put_word(32'h0123_4567, MAX_BYTES, 1'b0);
		put_word(32'h89AB_CDEF, 3'd0, 1'b1);
		settle();
		// top seed: fifteen bytes and an empty message
		write_seed('1);
		repeat (3) put_word($urandom, MAX_BYTES, 1'b0);
		put_word($urandom, 3'd3, 1'b1);
		put_word('0, 3'd0, 1'b1);

		phase = 0;
		while (rand_items < RANDOM_ITEMS) begin
			settle();
			write_seed(pick_seed(phase));
			// hold the receiver off while words keep coming
			if (phase == 1)
				hold_reqs++;
			for (m = 0; m < 12 && rand_items < RANDOM_ITEMS; m++)
				send_message($urandom_range(0, 4) == 0);
			phase++;
		end
		settle();

		if (mismatches == 0 && pending == 0)
			$display("xxhash32_stream_hasher: match");
		else
			$display("xxhash32_stream_hasher: mismatch");
		$finish;
	end

endmodule
